@@ rtl/core/pfde_pkg.sv @@
// Shared types and constants for the page framebuffer draw engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pfde_pkg;

  // Frame store geometry
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;

  // Command modes as they arrive on the input channel
  localparam logic [2:0] MODE_PIXEL = 3'd0;
  localparam logic [2:0] MODE_HLINE = 3'd1;
  localparam logic [2:0] MODE_VLINE = 3'd2;
  localparam logic [2:0] MODE_RECT  = 3'd3;
  localparam logic [2:0] MODE_FILL  = 3'd4;
  localparam logic [2:0] MODE_CLEAR = 3'd5;
  localparam logic [2:0] MODE_READ  = 3'd6;

  // Job kinds handed from the front end to the draw back end
  localparam logic [1:0] KIND_WALK  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One job: a rectangular pixel walk, a store clear, a byte read, or nothing.
  // last marks the job that closes a command and owes its result word.
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        x0;
    logic [7:0]        y0;
    logic [7:0]        ncols;
    logic [8:0]        nrows;
    logic              pix_on;
    logic [ADDR_W-1:0] ridx;
    logic              last;
  } job_t;

endpackage

@@ rtl/core/pfde_queue.sv @@
// Small job FIFO that decouples the command front end from the draw back end.
// Depends on pfde_pkg for the job type and depth.
`timescale 1ns / 1ps

module pfde_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pfde_pkg::job_t push_job,
  input  logic          pop,
  output pfde_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import pfde_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/pfde_front.sv @@
// Command front end: takes input words, classifies the mode and splits each
// command into draw jobs for the queue. Depends on pfde_pkg.
`timescale 1ns / 1ps

module pfde_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          hold,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_mode,
  input  logic [7:0]    in_x_start,
  input  logic [7:0]    in_y_start,
  input  logic [7:0]    in_x_end,
  input  logic [7:0]    in_y_end,
  input  logic [7:0]    in_line_length,
  input  logic          in_pixel_on,
  input  logic [9:0]    in_read_index,
  input  logic          q_full,
  output logic          q_push,
  output pfde_pkg::job_t q_job
);
  import pfde_pkg::*;

  logic       busy_r, busy_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic [2:0] mode_r;
  logic [7:0] xs_r, ys_r, xe_r, ye_r, len_r;
  logic       on_r;
  logic [9:0] ridx_r;

  logic [7:0] wid;
  logic [7:0] hgt;
  logic [1:0] last_seg;
  logic       accept;

  assign in_ready = !busy_r && !hold;
  assign accept   = in_valid && in_ready;
  assign wid      = xe_r - xs_r + 8'd1;
  assign hgt      = ye_r - ys_r;
  // outline splits into two horizontal and two vertical walks
  assign last_seg = (mode_r == MODE_RECT) ? 2'd3 : 2'd0;
  assign q_push   = busy_r && !q_full;

  always_comb begin
    q_job        = '0;
    q_job.kind   = KIND_WALK;
    q_job.x0     = xs_r;
    q_job.y0     = ys_r;
    q_job.ncols  = 8'd1;
    q_job.nrows  = 9'd1;
    q_job.pix_on = 1'b1;
    q_job.ridx   = ridx_r;
    q_job.last   = (seg_r == last_seg);
    case (mode_r)
      MODE_PIXEL: q_job.pix_on = on_r;
      MODE_HLINE: q_job.ncols  = len_r;
      MODE_VLINE: q_job.nrows  = {1'b0, len_r};
      MODE_RECT: begin
        case (seg_r)
          2'd0: q_job.ncols = wid;
          2'd1: begin
            q_job.y0    = ye_r;
            q_job.ncols = wid;
          end
          2'd2: q_job.nrows = {1'b0, hgt};
          default: begin
            q_job.x0    = xe_r;
            q_job.nrows = {1'b0, hgt};
          end
        endcase
      end
      MODE_FILL: begin
        q_job.ncols = wid;
        q_job.nrows = {1'b0, hgt} + 9'd1;
      end
      MODE_CLEAR: q_job.kind = KIND_CLEAR;
      MODE_READ:  q_job.kind = KIND_READ;
      default:    q_job.kind = KIND_NOP;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    seg_nxt  = seg_r;
    if (accept) begin
      busy_nxt = 1'b1;
      seg_nxt  = 2'd0;
    end else if (q_push) begin
      if (seg_r == last_seg) begin
        busy_nxt = 1'b0;
        seg_nxt  = 2'd0;
      end else begin
        seg_nxt = seg_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      xs_r   <= in_x_start;
      ys_r   <= in_y_start;
      xe_r   <= in_x_end;
      ye_r   <= in_y_end;
      len_r  <= in_line_length;
      on_r   <= in_pixel_on;
      ridx_r <= in_read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      seg_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      seg_r  <= seg_nxt;
    end
  end

endmodule

@@ rtl/core/pfde_back.sv @@
// Draw back end: owns the frame store, walks pixels by read-modify-write,
// sweeps clears and reads bytes, and holds the result register. Depends on pfde_pkg.
`timescale 1ns / 1ps

module pfde_back #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pfde_pkg::job_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          init_busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_read_byte
);
  import pfde_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRD  = 3'd1;
  localparam logic [2:0] ST_PWR  = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_RDW  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic [8:0]  PW9   = 9'(PANEL_WIDTH);
  localparam logic [8:0]  PH9   = 9'(PANEL_HEIGHT);
  localparam logic [7:0]  PW8   = 8'(PANEL_WIDTH);
  localparam logic [13:0] DEPTH = 14'(STORE_DEPTH);

  logic [2:0]        state_r, state_nxt;
  logic              init_r, init_nxt;
  logic [7:0]        i_r, i_nxt;
  logic [7:0]        j_r, j_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [7:0]        result_r, result_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;

  logic [7:0]        mem_r [STORE_DEPTH];
  logic [7:0]        rdata_r;
  logic              we;
  logic [ADDR_W-1:0] wa, ra;
  logic [7:0]        wd;

  logic [7:0]  cx, cy;
  logic [12:0] page_off;
  logic [13:0] pix_addr;
  logic        on_panel;
  logic [7:0]  bit_mask;
  logic        row_end, col_end, out_free;

  // current pixel of the walk, wrapping modulo 256
  assign cx       = head.x0 + i_r;
  assign cy       = head.y0 + j_r;
  assign page_off = {8'd0, cy[7:3]} * {5'd0, PW8};
  assign pix_addr = {6'd0, cx} + {1'b0, page_off};
  assign on_panel = ({1'b0, cx} < PW9) && ({1'b0, cy} < PH9) && (pix_addr < DEPTH);
  assign bit_mask = 8'd1 << cy[2:0];
  assign row_end  = ({1'b0, j_r} + 9'd1) >= head.nrows;
  assign col_end  = ({1'b0, i_r} + 9'd1) >= {1'b0, head.ncols};
  assign out_free = !out_valid_r || out_ready;

  assign init_busy     = init_r;
  assign out_valid     = out_valid_r;
  assign out_read_byte = out_byte_r;

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    clr_nxt       = clr_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    wa            = pix_addr[ADDR_W-1:0];
    wd            = head.pix_on ? (rdata_r | bit_mask) : (rdata_r & ~bit_mask);
    ra            = pix_addr[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        i_nxt   = 8'd0;
        j_nxt   = 8'd0;
        clr_nxt = '0;
        ra      = head.ridx;
        if (!q_empty) begin
          case (head.kind)
            KIND_WALK: begin
              if (head.ncols == 8'd0 || head.nrows == 9'd0) begin
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_PRD;
              end
            end
            KIND_CLEAR: state_nxt = ST_CLR;
            KIND_READ:  state_nxt = ST_RDW;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_PRD, ST_PWR: begin
        // pixels off the panel skip the write cycle
        if (state_r == ST_PRD && on_panel) begin
          state_nxt = ST_PWR;
        end else begin
          we = (state_r == ST_PWR);
          if (row_end) begin
            j_nxt = 8'd0;
            i_nxt = i_r + 8'd1;
          end else begin
            j_nxt = j_r + 8'd1;
          end
          state_nxt = (row_end && col_end) ? ST_FIN : ST_PRD;
        end
      end
      ST_CLR: begin
        we      = 1'b1;
        wa      = clr_r;
        wd      = 8'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? ST_IDLE : ST_FIN;
        end
      end
      ST_RDW: begin
        result_nxt = rdata_r;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (!head.last) begin
          q_pop     = 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = (head.kind == KIND_READ) ? result_r : 8'd0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rdata_r <= mem_r[ra];
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    result_r   <= result_nxt;
    out_byte_r <= out_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      init_r      <= 1'b1;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/page_framebuffer_draw_engine.sv @@
// Top level of the page framebuffer draw engine: front end, job queue, back end.
// Depends on pfde_pkg, pfde_front, pfde_queue and pfde_back.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in_     | input     | in_valid / in_ready   | mode, corners, length, pixel, index
//  out_    | output    | out_valid / out_ready | read_byte, one word per command
//
//  Cost: a drawn pixel on the panel takes a read then a write of the store; an
//  off-panel pixel skips the write. Each job also passes dispatch and finish. A
//  clear sweeps every store byte. An outline is four jobs.
//  Reset: every store byte is swept to zero after reset; in_ready is low
//  during that pass.
//  Stalls: the job queue lets the front take the next command while the back draws;
//  a result waits in the output register; the next one stalls the back until taken.

module page_framebuffer_draw_engine #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_mode,
  input  logic [7:0] in_x_start,
  input  logic [7:0] in_y_start,
  input  logic [7:0] in_x_end,
  input  logic [7:0] in_y_end,
  input  logic [7:0] in_line_length,
  input  logic       in_pixel_on,
  input  logic [9:0] in_read_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_byte
);
  import pfde_pkg::*;

  job_t push_job;
  job_t head;
  logic q_push, q_pop, q_full, q_empty;
  logic init_busy;

  // front: one command word in, one to four jobs out
  pfde_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold           (init_busy),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_line_length (in_line_length),
    .in_pixel_on    (in_pixel_on),
    .in_read_index  (in_read_index),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  pfde_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: frame store and the result register
  pfde_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_byte (out_read_byte)
  );

  // the back end only retires a job that is really queued
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // the front end never pushes into a full queue
  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // a command closes only when the output register can take its word
  a_result_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head.last) |-> (!out_valid || out_ready))
    else $error("result word would overwrite a pending one");

  // the store is never drawn while the reset sweep is still running
  a_init_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !q_pop)
    else $error("job retired during reset sweep");

endmodule

@@ tb/page_framebuffer_draw_engine_tb.sv @@
// Self-checking testbench for page_framebuffer_draw_engine: draw commands go in,
// a shadow frame store predicts every result word. Depends on pfde_pkg and the RTL.
`timescale 1ns / 1ps

module page_framebuffer_draw_engine_tb;
  import pfde_pkg::*;

  // Panel geometry handed to the DUT; the shadow store uses the same values.
  localparam int PANEL_W = 128;
  localparam int PANEL_H = 64;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 5;
  // Sized for the worst single command, a near-full wrapped fill, and for the store
  // sweep after reset.
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_ITEMS   = 1320;

  // Mode 7 has no package name; the block treats it as a no-op.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  // Receiver stall styles
  localparam int RX_ALWAYS      = 0;
  localparam int RX_MOSTLY_HIGH = 1;
  localparam int RX_MOSTLY_LOW  = 2;
  localparam int RX_EVERY_THIRD = 3;

  typedef struct {
    logic [2:0] mode;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic [7:0] line_length;
    logic       pixel_on;
    logic [9:0] read_index;
  } draw_cmd_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_mode;
  logic [7:0] in_x_start;
  logic [7:0] in_y_start;
  logic [7:0] in_x_end;
  logic [7:0] in_y_end;
  logic [7:0] in_line_length;
  logic       in_pixel_on;
  logic [9:0] in_read_index;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_read_byte;

  // Shadow of the frame store and the queue of read_byte words still owed.
  logic [7:0] shadow_store [0:STORE_DEPTH-1];
  logic [7:0] expected_read_bytes [$];

  int fail_count;
  int idle_cycles = 0;
  int burst_left;
  bit gaps_enabled;
  bit hold_request;

  page_framebuffer_draw_engine #(
    .PANEL_WIDTH  (PANEL_W),
    .PANEL_HEIGHT (PANEL_H)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_line_length (in_line_length),
    .in_pixel_on    (in_pixel_on),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_byte  (out_read_byte)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow store: pixel (x, y) sits in byte x + (y / 8) * width, bit y mod 8.
  // Coordinates wrap at 256; anything off the panel or past the store is dropped.
  // ---------------------------------------------------------------------------
  task automatic shadow_plot(input int x, input int y, input bit on);
    int px;
    int py;
    int addr;
    px = x & 255;
    py = y & 255;
    if (px >= PANEL_W || py >= PANEL_H) return;
    addr = px + (py >> 3) * PANEL_W;
    if (addr >= STORE_DEPTH) return;
    shadow_store[addr][py & 7] = on;
  endtask

  task automatic shadow_hline(input int x, input int y, input int len);
    int i;
    for (i = 0; i < len; i++) shadow_plot(x + i, y, 1'b1);
  endtask

  task automatic shadow_vline(input int x, input int y, input int len);
    int i;
    for (i = 0; i < len; i++) shadow_plot(x, y + i, 1'b1);
  endtask

  // Applies one command to the shadow store and yields the word the block owes.
  task automatic predict_read_byte(input draw_cmd_t c, output logic [7:0] rd);
    int wid;
    int hgt;
    int i;
    int j;
    // rectangle width counts both corner columns; height is the raw difference
    wid = (int'(c.x_end) - int'(c.x_start) + 1) & 255;
    hgt = (int'(c.y_end) - int'(c.y_start)) & 255;
    rd = 8'h00;
    case (c.mode)
      MODE_PIXEL: shadow_plot(int'(c.x_start), int'(c.y_start), c.pixel_on);
      MODE_HLINE: shadow_hline(int'(c.x_start), int'(c.y_start), int'(c.line_length));
      MODE_VLINE: shadow_vline(int'(c.x_start), int'(c.y_start), int'(c.line_length));
      MODE_RECT: begin
        shadow_hline(int'(c.x_start), int'(c.y_start), wid);
        shadow_hline(int'(c.x_start), int'(c.y_end), wid);
        shadow_vline(int'(c.x_start), int'(c.y_start), hgt);
        shadow_vline(int'(c.x_end), int'(c.y_start), hgt);
      end
      MODE_FILL: begin
        for (i = 0; i < wid; i++)
          for (j = 0; j <= hgt; j++)
            shadow_plot(int'(c.x_start) + i, int'(c.y_start) + j, 1'b1);
      end
      MODE_CLEAR: begin
        for (i = 0; i < STORE_DEPTH; i++) shadow_store[i] = 8'h00;
      end
      MODE_READ: rd = shadow_store[c.read_index];
      default: ;  // unused mode: no change, zero word
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: mismatch, %s: expected %02h, got %02h", $time, what, want, got);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts at input acceptance, checks at output acceptance. Both
  // in one process so a push and a pop in the same edge keep a fixed order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    draw_cmd_t  taken;
    logic [7:0] want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        taken.mode        = in_mode;
        taken.x_start     = in_x_start;
        taken.y_start     = in_y_start;
        taken.x_end       = in_x_end;
        taken.y_end       = in_y_end;
        taken.line_length = in_line_length;
        taken.pixel_on    = in_pixel_on;
        taken.read_index  = in_read_index;
        predict_read_byte(taken, want);
        expected_read_bytes.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_read_bytes.size() == 0) begin
          report_mismatch("result word with no command pending", 8'h00, out_read_byte);
        end else begin
          want = expected_read_bytes.pop_front();
          if (out_read_byte !== want) report_mismatch("read_byte", want, out_read_byte);
        end
      end
    end
  end

  // Watchdog: any word moving on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("[page_framebuffer_draw_engine] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: picks a new style after each random stretch (including a no-stall style);
  // a hold request forces a long stretch of ready low, counted here.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int style;
    int stretch;
    int k;
    out_ready = 1'b0;
    style = RX_ALWAYS;
    stretch = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 1'b0;
        for (k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (stretch == 0) begin
          style = $urandom_range(RX_ALWAYS, RX_EVERY_THIRD);
          stretch = $urandom_range(32, 256);
        end
        stretch--;
        case (style)
          RX_ALWAYS:      out_ready = 1'b1;
          RX_MOSTLY_HIGH: out_ready = ($urandom_range(0, 9) < 8);
          RX_MOSTLY_LOW:  out_ready = ($urandom_range(0, 9) < 3);
          default:        out_ready = (stretch % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  function automatic draw_cmd_t make_cmd(input logic [2:0] mode, input logic [7:0] xs,
                                         input logic [7:0] ys, input logic [7:0] xe,
                                         input logic [7:0] ye, input logic [7:0] len,
                                         input logic on, input logic [9:0] ridx);
    draw_cmd_t c;
    c.mode = mode;
    c.x_start = xs;
    c.y_start = ys;
    c.x_end = xe;
    c.y_end = ye;
    c.line_length = len;
    c.pixel_on = on;
    c.read_index = ridx;
    return c;
  endfunction

  function automatic logic [9:0] pixel_addr(input int x, input int y);
    return 10'(x + (y / 8) * PANEL_W);
  endfunction

  // Offers one word and returns once it is taken. Between bursts valid drops
  // for a random gap; valid never drops while a word is pending.
  task automatic send_command(input draw_cmd_t c);
    int gap;
    if (gaps_enabled && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_valid       = 1'b1;
    in_mode        = c.mode;
    in_x_start     = c.x_start;
    in_y_start     = c.y_start;
    in_x_end       = c.x_end;
    in_y_end       = c.y_end;
    in_line_length = c.line_length;
    in_pixel_on    = c.pixel_on;
    in_read_index  = c.read_index;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic read_back(input logic [9:0] idx);
    send_command(make_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, idx));
  endtask

  // Drops valid and waits for every owed word to come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_read_bytes.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner pixels, set and clear, off-panel pixels, reads at both store ends.
  task automatic test_pixels();
    send_command(make_cmd(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0));
    send_command(make_cmd(MODE_PIXEL, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0));
    send_command(make_cmd(MODE_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0));
    send_command(make_cmd(MODE_PIXEL, 8'd128, 8'd5, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0));
    send_command(make_cmd(MODE_PIXEL, 8'd3, 8'd64, 8'd0, 8'd0, 8'd0, 1'b1, 10'd0));
    send_command(make_cmd(MODE_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1,
                          10'h3FF));
    send_command(make_cmd(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0));
    read_back(10'd0);
    read_back(10'h3FF);
  endtask

  // Zero length, wrap past 255 back onto the panel, full-length lines.
  task automatic test_lines();
    send_command(make_cmd(MODE_HLINE, 8'd10, 8'd10, 8'd0, 8'd0, 8'd0, 1'b0, 10'd0));
    send_command(make_cmd(MODE_HLINE, 8'd250, 8'd9, 8'd0, 8'd0, 8'd20, 1'b0, 10'd0));
    send_command(make_cmd(MODE_VLINE, 8'd5, 8'd250, 8'd0, 8'd0, 8'd20, 1'b0, 10'd0));
    send_command(make_cmd(MODE_HLINE, 8'd0, 8'd62, 8'd0, 8'd0, 8'd255, 1'b0, 10'd0));
    send_command(make_cmd(MODE_VLINE, 8'd126, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 10'd0));
    read_back(pixel_addr(0, 9));
    read_back(pixel_addr(5, 8));
  endtask

  // Normal and wrapped outlines, zero-width fill, wrapped fill, near-full fill.
  task automatic test_rectangles();
    send_command(make_cmd(MODE_RECT, 8'd10, 8'd20, 8'd30, 8'd40, 8'd0, 1'b0, 10'd0));
    send_command(make_cmd(MODE_RECT, 8'd120, 8'd60, 8'd5, 8'd3, 8'd0, 1'b0, 10'd0));
    send_command(make_cmd(MODE_FILL, 8'd50, 8'd30, 8'd49, 8'd35, 8'd0, 1'b0, 10'd0));
    read_back(pixel_addr(50, 30));
    send_command(make_cmd(MODE_FILL, 8'd200, 8'd200, 8'd8, 8'd4, 8'd0, 1'b0, 10'd0));
    read_back(pixel_addr(3, 0));
    send_command(make_cmd(MODE_FILL, 8'd0, 8'd0, 8'd254, 8'd255, 8'd0, 1'b0, 10'd0));
    read_back(pixel_addr(64, 32));
  endtask

  // Unused mode leaves the store alone; clear wipes it.
  task automatic test_clear_and_unused();
    send_command(make_cmd(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 10'h3FF));
    send_command(make_cmd(MODE_CLEAR, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1, 10'h155));
    read_back(10'h200);
  endtask

  // Receiver holds off while the sender keeps offering back-to-back words, so
  // the job queue and result register fill and in_ready drops.
  task automatic test_backpressure();
    int k;
    wait_drained();
    gaps_enabled = 1'b0;
    hold_request = 1'b1;
    for (k = 0; k < 24; k++) begin
      if (k % 2 == 0)
        send_command(make_cmd(MODE_PIXEL, 8'($urandom_range(0, PANEL_W - 1)),
                              8'($urandom_range(0, PANEL_H - 1)), 8'd0, 8'd0, 8'd0,
                              1'($urandom_range(0, 1)), 10'd0));
      else
        read_back(10'($urandom_range(0, STORE_DEPTH - 1)));
    end
    wait_drained();
    gaps_enabled = 1'b1;
  endtask

  // Mostly draw-then-read-back sequences on the panel, some clears, and noise
  // with every field fully random.
  task automatic test_random();
    draw_cmd_t c;
    int sent;
    int round;
    int r;
    int k;
    int span_x;
    int span_y;
    int px;
    int py;
    sent = 0;
    round = 0;
    while (sent < RANDOM_ITEMS) begin
      round++;
      if (round % 60 == 0) gaps_enabled = ($urandom_range(0, 2) != 0);
      if (round % 150 == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 75) begin
        c = make_cmd(3'($urandom_range(MODE_PIXEL, MODE_FILL)),
                     8'($urandom_range(0, PANEL_W - 1)),
                     8'($urandom_range(0, PANEL_H - 1)), 8'd0, 8'd0, 8'd0,
                     1'($urandom_range(0, 1)), 10'($urandom_range(0, STORE_DEPTH - 1)));
        // small spans mostly; large fills stay rare since they take longest to draw
        if ($urandom_range(0, 99) == 0) begin
          span_x = $urandom_range(0, 255);
          span_y = $urandom_range(0, 255);
        end else if ($urandom_range(0, 9) == 0) begin
          span_x = $urandom_range(0, 63);
          span_y = $urandom_range(0, 63);
        end else begin
          span_x = $urandom_range(0, 15);
          span_y = $urandom_range(0, 15);
        end
        c.x_end = 8'(int'(c.x_start) + span_x);
        c.y_end = 8'(int'(c.y_start) + span_y);
        c.line_length = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 32));
        case (c.mode)
          MODE_PIXEL: begin
            span_x = 0;
            span_y = 0;
          end
          MODE_HLINE: begin
            span_x = int'(c.line_length);
            span_y = 0;
          end
          MODE_VLINE: begin
            span_x = 0;
            span_y = int'(c.line_length);
          end
          default: ;
        endcase
        send_command(c);
        sent++;
        // read back bytes inside the drawn area
        for (k = $urandom_range(1, 3); k > 0; k--) begin
          px = (int'(c.x_start) + $urandom_range(0, span_x)) & 255;
          py = (int'(c.y_start) + $urandom_range(0, span_y)) & 255;
          if (px < PANEL_W && py < PANEL_H) read_back(pixel_addr(px, py));
          else read_back(10'($urandom_range(0, STORE_DEPTH - 1)));
          sent++;
        end
      end else if (r < 78) begin
        send_command(make_cmd(MODE_CLEAR, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)),
                              10'($urandom_range(0, STORE_DEPTH - 1))));
        sent++;
      end else begin
        c = make_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 10'($urandom_range(0, STORE_DEPTH - 1)));
        // keep noisy fills short in height so the run stays bounded
        if (c.mode == MODE_FILL) c.y_end = 8'(int'(c.y_start) + $urandom_range(0, 7));
        send_command(c);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_PIXEL;
    in_x_start     = 8'd0;
    in_y_start     = 8'd0;
    in_x_end       = 8'd0;
    in_y_end       = 8'd0;
    in_line_length = 8'd0;
    in_pixel_on    = 1'b0;
    in_read_index  = 10'd0;
    fail_count     = 0;
    burst_left     = 0;
    gaps_enabled   = 1'b1;
    hold_request   = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = 8'h00;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // in_ready stays low through the post-reset sweep; the first send waits it out
    test_pixels();
    test_lines();
    test_rectangles();
    test_clear_and_unused();
    wait_drained();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[page_framebuffer_draw_engine] OK");
    end else begin
      $display("[page_framebuffer_draw_engine] ERROR");
    end
    $finish;
  end

endmodule
